// ===== sv/rational_gcd_reducer_macros.svh =====
// ----------------------------------------------------------------------------
// rational gcd reducer assertion macros
// shorthand for clocked implication checks, reset disables each check
// ----------------------------------------------------------------------------
`ifndef RATIONAL_GCD_REDUCER_MACROS_SVH
`define RATIONAL_GCD_REDUCER_MACROS_SVH

// same-cycle implication
`define RGR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rational_gcd_reducer check failed");

// next-cycle implication
`define RGR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rational_gcd_reducer check failed");

`endif

// ===== sv/rgr_pkg.sv =====
// ----------------------------------------------------------------------------
// rgr_pkg
// shared widths, tag type codes, byte order helpers and divider bundles
// ----------------------------------------------------------------------------
package rgr_pkg;

  localparam int WORD_W = 32;
  localparam int TYPE_W = 16;
  localparam int CNT_W  = $clog2(WORD_W);

  localparam logic [TYPE_W-1:0] TYPE_URATIONAL = 16'd5;
  localparam logic [TYPE_W-1:0] TYPE_SRATIONAL = 16'd10;

  localparam logic [WORD_W-1:0] WORD_MIN_NEG = {1'b1, {(WORD_W-1){1'b0}}};

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] dividend;
    logic [WORD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] quotient;
    logic [WORD_W-1:0] remainder;
  } div_rsp_t;

  function automatic logic [TYPE_W-1:0] swap16(input logic [TYPE_W-1:0] v);
    return {v[7:0], v[15:8]};
  endfunction

  function automatic logic [WORD_W-1:0] swap32(input logic [WORD_W-1:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  function automatic logic [WORD_W-1:0] magnitude(input logic [WORD_W-1:0] v);
    return v[WORD_W-1] ? (~v + WORD_W'(1)) : v;
  endfunction

endpackage

// ===== sv/rgr_div.sv =====
// ----------------------------------------------------------------------------
// rgr_div
// restoring unsigned divider, one quotient bit per cycle, shared by the
// euclid remainder steps and the final reductions
// ----------------------------------------------------------------------------
module rgr_div (
  input  logic              clk,
  input  logic              rst,
  input  rgr_pkg::div_req_t req,
  output rgr_pkg::div_rsp_t rsp
);

  logic                       busy;
  logic                       done;
  logic [rgr_pkg::CNT_W-1:0]  count;
  logic [rgr_pkg::WORD_W-1:0] rem;
  logic [rgr_pkg::WORD_W-1:0] quo;
  logic [rgr_pkg::WORD_W-1:0] dvs;

  logic [rgr_pkg::WORD_W:0]   trial;
  logic [rgr_pkg::WORD_W:0]   diff;
  logic                       qbit;
  logic [rgr_pkg::WORD_W-1:0] rem_next;

  always_comb begin
    trial    = {rem, quo[rgr_pkg::WORD_W-1]};
    diff     = trial - {1'b0, dvs};
    qbit     = ~diff[rgr_pkg::WORD_W];
    rem_next = qbit ? diff[rgr_pkg::WORD_W-1:0] : trial[rgr_pkg::WORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + rgr_pkg::CNT_W'(1);
        if (count == rgr_pkg::CNT_W'(rgr_pkg::WORD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dvs <= req.divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[rgr_pkg::WORD_W-2:0], qbit};
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

// ===== sv/rational_gcd_reducer.sv =====
// ----------------------------------------------------------------------------
// rational_gcd_reducer
// decodes one rational tag item and reduces it to lowest terms
// ----------------------------------------------------------------------------
// One item at a time. An absent tag, a non-rational type or a zero part
// goes straight to the done state. Otherwise every division runs on one
// shared restoring divider: an item runs k euclid remainder steps and then
// two final divisions (the signed case with both parts at the most negative
// value skips the two final divisions). k is 1 for many inputs and at most
// about 46 for 32-bit operands. A finished item waits in the output
// register, and the next item may be taken while it waits.
module rational_gcd_reducer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic                        cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        tag_present,
  input  logic [rgr_pkg::TYPE_W-1:0]  type_raw,
  input  logic [rgr_pkg::WORD_W-1:0]  numerator_raw,
  input  logic [rgr_pkg::WORD_W-1:0]  denominator_raw,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rgr_pkg::TYPE_W-1:0]  type_out,
  output logic [rgr_pkg::WORD_W-1:0]  numerator_out,
  output logic [rgr_pkg::WORD_W-1:0]  denominator_out
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_GCD_GO   = 3'd1;
  localparam logic [2:0] S_GCD_WAIT = 3'd2;
  localparam logic [2:0] S_NUM_GO   = 3'd3;
  localparam logic [2:0] S_NUM_WAIT = 3'd4;
  localparam logic [2:0] S_DEN_GO   = 3'd5;
  localparam logic [2:0] S_DEN_WAIT = 3'd6;
  localparam logic [2:0] S_DONE     = 3'd7;

  logic [2:0] state;
  logic       little_endian;

  logic                       is_signed;
  logic                       neg_n;
  logic                       neg_d;
  logic [rgr_pkg::WORD_W-1:0] mag_n;
  logic [rgr_pkg::WORD_W-1:0] mag_d;
  logic [rgr_pkg::WORD_W-1:0] op_a;
  logic [rgr_pkg::WORD_W-1:0] op_b;
  logic [rgr_pkg::WORD_W-1:0] gcd;
  logic [rgr_pkg::TYPE_W-1:0] res_type;
  logic [rgr_pkg::WORD_W-1:0] res_num;
  logic [rgr_pkg::WORD_W-1:0] res_den;

  logic [rgr_pkg::TYPE_W-1:0] dec_type;
  logic [rgr_pkg::WORD_W-1:0] dec_num;
  logic [rgr_pkg::WORD_W-1:0] dec_den;
  logic                       dec_rational;
  logic                       dec_signed;
  logic                       accept;
  logic                       out_load;

  rgr_pkg::div_req_t div_req;
  rgr_pkg::div_rsp_t div_rsp;

  rgr_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // byte order and type decode
  always_comb begin
    dec_type     = little_endian ? type_raw : rgr_pkg::swap16(type_raw);
    dec_num      = little_endian ? numerator_raw : rgr_pkg::swap32(numerator_raw);
    dec_den      = little_endian ? denominator_raw : rgr_pkg::swap32(denominator_raw);
    dec_signed   = (dec_type == rgr_pkg::TYPE_SRATIONAL);
    dec_rational = dec_signed || (dec_type == rgr_pkg::TYPE_URATIONAL);
  end

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_load = (state == S_DONE) && (!out_valid || out_ready);

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = op_a;
    div_req.divisor  = op_b;
    unique case (state)
      S_GCD_GO: begin
        div_req.start = 1'b1;
      end
      S_NUM_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = mag_n;
        div_req.divisor  = gcd;
      end
      S_DEN_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = mag_d;
        div_req.divisor  = gcd;
      end
      S_NUM_WAIT: begin
        div_req.dividend = mag_n;
        div_req.divisor  = gcd;
      end
      S_DEN_WAIT: begin
        div_req.dividend = mag_d;
        div_req.divisor  = gcd;
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      little_endian <= 1'b1;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        little_endian <= cfg_wdata;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (tag_present && dec_rational && (dec_num != '0) && (dec_den != '0)) begin
              state <= S_GCD_GO;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_GCD_GO:   state <= S_GCD_WAIT;
        S_GCD_WAIT: begin
          if (div_rsp.done) begin
            if (div_rsp.remainder != '0) begin
              state <= S_GCD_GO;
            end else if (is_signed && (op_b == rgr_pkg::WORD_MIN_NEG)) begin
              state <= S_DONE;
            end else begin
              state <= S_NUM_GO;
            end
          end
        end
        S_NUM_GO:   state <= S_NUM_WAIT;
        S_NUM_WAIT: begin
          if (div_rsp.done) begin
            state <= S_DEN_GO;
          end
        end
        S_DEN_GO:   state <= S_DEN_WAIT;
        S_DEN_WAIT: begin
          if (div_rsp.done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      is_signed <= dec_signed;
      neg_n     <= dec_signed && dec_num[rgr_pkg::WORD_W-1];
      neg_d     <= dec_signed && dec_den[rgr_pkg::WORD_W-1];
      mag_n     <= dec_signed ? rgr_pkg::magnitude(dec_num) : dec_num;
      mag_d     <= dec_signed ? rgr_pkg::magnitude(dec_den) : dec_den;
      op_a      <= dec_signed ? rgr_pkg::magnitude(dec_num) : dec_num;
      op_b      <= dec_signed ? rgr_pkg::magnitude(dec_den) : dec_den;
      res_type  <= tag_present ? dec_type : '0;
      res_num   <= (tag_present && dec_rational) ? dec_num : '0;
      res_den   <= (tag_present && dec_rational) ? dec_den : '0;
    end
    if ((state == S_GCD_WAIT) && div_rsp.done) begin
      if (div_rsp.remainder != '0) begin
        op_a <= op_b;
        op_b <= div_rsp.remainder;
      end else begin
        gcd <= op_b;
        if (is_signed && (op_b == rgr_pkg::WORD_MIN_NEG)) begin
          res_num <= rgr_pkg::WORD_W'(1);
          res_den <= rgr_pkg::WORD_W'(1);
        end
      end
    end
    if ((state == S_NUM_WAIT) && div_rsp.done) begin
      res_num <= neg_n ? (~div_rsp.quotient + rgr_pkg::WORD_W'(1)) : div_rsp.quotient;
    end
    if ((state == S_DEN_WAIT) && div_rsp.done) begin
      res_den <= neg_d ? (~div_rsp.quotient + rgr_pkg::WORD_W'(1)) : div_rsp.quotient;
    end
    if (out_load) begin
      type_out        <= res_type;
      numerator_out   <= res_num;
      denominator_out <= res_den;
    end
  end

endmodule

// ===== sv/rgr_checker.sv =====
// ----------------------------------------------------------------------------
// rgr_checker
// port-level checks on the rational gcd reducer, bound to the top level
// ----------------------------------------------------------------------------
`include "rational_gcd_reducer_macros.svh"

module rgr_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [rgr_pkg::TYPE_W-1:0]  type_out,
  input logic [rgr_pkg::WORD_W-1:0]  numerator_out,
  input logic [rgr_pkg::WORD_W-1:0]  denominator_out
);

  logic is_rational;

  assign is_rational = (type_out == rgr_pkg::TYPE_URATIONAL) ||
                       (type_out == rgr_pkg::TYPE_SRATIONAL);

  // a stalled result item holds
  `RGR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(numerator_out) && $stable(denominator_out) && $stable(type_out))

  // one item in work at a time
  `RGR_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready)

  // non-rational or absent tags give 0/0
  `RGR_ASSERT_IMPL(a_non_rational_zero, out_valid && !is_rational, numerator_out == '0 && denominator_out == '0)

  // a reduced fraction never has both parts even
  `RGR_ASSERT_IMPL(a_reduced_odd, out_valid && is_rational && numerator_out != '0 && denominator_out != '0, numerator_out[0] || denominator_out[0])

endmodule

bind rational_gcd_reducer rgr_checker u_rgr_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .type_out        (type_out),
  .numerator_out   (numerator_out),
  .denominator_out (denominator_out)
);
